// ===== hdl/multi_slot_alarm_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-slot alarm scheduler
// Shared clocked, reset-gated wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_ALARM_SCHEDULER_MACROS_SVH
`define MULTI_SLOT_ALARM_SCHEDULER_MACROS_SVH

// Property checked at every clock edge while out of reset.
`define MSAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define MSAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msas_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm scheduler package
// Slot count, opcodes, status codes and the beat types of both channels.
// ----------------------------------------------------------------------------
package msas_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [31:0] TIME_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET       = 3'd1,
    OP_GET       = 3'd2,
    OP_SCAN      = 3'd3,
    OP_CLR_TICK  = 3'd4,
    OP_CLR_FIRED = 3'd5
  } opcode_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_SLOT = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot_index;
    logic [31:0] alarm_time;
    logic        enable;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] slot_time;
    logic        slot_armed;
    logic [31:0] current_time;
    logic [31:0] next_due_time;
    logic        tick_event;
    logic [15:0] fired_mask;
    logic [15:0] armed_mask;
  } out_item_t;

endpackage

// ===== hdl/multi_slot_alarm_scheduler.sv =====
// ----------------------------------------------------------------------------
// Multi-slot alarm scheduler
// Tick counter, alarm slots and a scan sequencer sharing one 32-bit comparator.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------
//  input   | start / busy       | in_item  (msas_pkg::in_item_t)
//  result  | out_valid (strobe) | out_item (msas_pkg::out_item_t)
//
// Every input beat gives exactly one result beat, shown in the first cycle
// in which busy is low again.
// Clear, unused opcodes, out-of-range slots and a scan with nothing armed go
// straight to S_OUT; tick, set and get pass S_TICK_CMP, S_SET_CMP or S_GET_WAIT.
// A scan reads each armed slot in S_SCAN_RD, tests it in S_SCAN_LE and a pending
// one in S_SCAN_MIN, an order set by the single comparator and one-port memory.
// Reset (synchronous, active low) empties the slots; no clearing pass is needed.
// Results cannot be stalled; a new item may start while a result is shown.
// ----------------------------------------------------------------------------
module multi_slot_alarm_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  msas_pkg::in_item_t  in_item,
  output logic                out_valid,
  output msas_pkg::out_item_t out_item
);
  import msas_pkg::*;

  `include "multi_slot_alarm_scheduler_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CMP,
    S_SET_CMP,
    S_GET_WAIT,
    S_SCAN_RD,
    S_SCAN_LE,
    S_SCAN_MIN,
    S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  in_item_t                item_r, item_nxt;
  logic [31:0]             tick_r, tick_nxt;
  logic [31:0]             due_r, due_nxt;
  logic [31:0]             least_r, least_nxt;
  logic [SLOT_COUNT-1:0]   armed_r, armed_nxt;
  logic [SLOT_COUNT-1:0]   fired_r, fired_nxt;
  logic [SLOT_COUNT-1:0]   valid_r, valid_nxt;
  logic                    flag_r, flag_nxt;
  logic [SLOT_IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                    status_r, status_nxt;
  logic [31:0]             get_time_r, get_time_nxt;
  logic                    get_armed_r, get_armed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r, out_nxt;

  // Slot time memory: one write port, one registered read port.
  logic [31:0]             mem [SLOT_COUNT];
  logic                    mem_we;
  logic                    mem_re;
  logic [SLOT_IDX_W-1:0]   mem_addr;
  logic [31:0]             rd_data_r;
  logic                    rd_valid_r;
  logic [31:0]             slot_data;

  // Shared comparator.
  logic [31:0]             cmp_a, cmp_b;
  logic                    cmp_le;

  logic                    accept;
  logic                    in_range;
  logic [SLOT_IDX_W-1:0]   in_idx;
  logic [SLOT_IDX_W-1:0]   item_idx;
  logic                    scan_last;

  assign accept    = start && (state_r == S_IDLE);
  assign in_idx    = in_item.slot_index[SLOT_IDX_W-1:0];
  assign item_idx  = item_r.slot_index[SLOT_IDX_W-1:0];
  assign in_range  = {1'b0, in_item.slot_index} < 5'(SLOT_COUNT);
  assign scan_last = scan_idx_r == SLOT_IDX_W'(SLOT_COUNT - 1);
  assign cmp_le    = cmp_a <= cmp_b;
  // A slot never written since reset reads as zero.
  assign slot_data = rd_valid_r ? rd_data_r : 32'd0;

  always_comb begin
    unique case (state_r)
      S_TICK_CMP: begin
        cmp_a = due_r;
        cmp_b = tick_r;
      end
      S_SET_CMP: begin
        cmp_a = due_r;
        cmp_b = item_r.alarm_time;
      end
      S_SCAN_MIN: begin
        cmp_a = least_r;
        cmp_b = slot_data;
      end
      default: begin
        cmp_a = slot_data;
        cmp_b = tick_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    tick_nxt      = tick_r;
    due_nxt       = due_r;
    least_nxt     = least_r;
    armed_nxt     = armed_r;
    fired_nxt     = fired_r;
    valid_nxt     = valid_r;
    flag_nxt      = flag_r;
    scan_idx_nxt  = scan_idx_r;
    status_nxt    = status_r;
    get_time_nxt  = get_time_r;
    get_armed_nxt = get_armed_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = scan_idx_r;

    unique case (state_r)
      S_IDLE: begin
        mem_addr = in_idx;
        if (accept) begin
          item_nxt      = in_item;
          status_nxt    = STATUS_OK;
          get_time_nxt  = 32'd0;
          get_armed_nxt = 1'b0;
          state_nxt     = S_OUT;
          case (opcode_t'(in_item.opcode))
            OP_TICK: begin
              tick_nxt  = tick_r + 32'd1;
              state_nxt = S_TICK_CMP;
            end
            OP_SET: begin
              if (in_range) begin
                mem_we            = 1'b1;
                valid_nxt[in_idx] = 1'b1;
                armed_nxt[in_idx] = in_item.enable;
                state_nxt         = S_SET_CMP;
              end else begin
                status_nxt = STATUS_BAD_SLOT;
              end
            end
            OP_GET: begin
              if (in_range) begin
                mem_re    = 1'b1;
                state_nxt = S_GET_WAIT;
              end else begin
                status_nxt = STATUS_BAD_SLOT;
              end
            end
            OP_SCAN: begin
              if (armed_r != '0) begin
                scan_idx_nxt = '0;
                least_nxt    = TIME_ALL_ONES;
                state_nxt    = S_SCAN_RD;
              end
            end
            OP_CLR_TICK:  flag_nxt  = 1'b0;
            OP_CLR_FIRED: fired_nxt = '0;
            default: ;
          endcase
        end
      end
      S_TICK_CMP: begin
        if (cmp_le) begin
          flag_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_SET_CMP: begin
        // Lower next-due when the new time is earlier, armed or not.
        if (!cmp_le) begin
          due_nxt = item_r.alarm_time;
        end
        state_nxt = S_OUT;
      end
      S_GET_WAIT: begin
        get_time_nxt  = slot_data;
        get_armed_nxt = armed_r[item_idx];
        state_nxt     = S_OUT;
      end
      S_SCAN_RD: begin
        if (armed_r[scan_idx_r]) begin
          mem_re    = 1'b1;
          state_nxt = S_SCAN_LE;
        end else if (scan_last) begin
          due_nxt   = least_r;
          state_nxt = S_OUT;
        end else begin
          scan_idx_nxt = scan_idx_r + SLOT_IDX_W'(1);
        end
      end
      S_SCAN_LE: begin
        if (cmp_le) begin
          // Slot is due: retire it.
          armed_nxt[scan_idx_r] = 1'b0;
          fired_nxt[scan_idx_r] = 1'b1;
          if (scan_last) begin
            due_nxt   = least_r;
            state_nxt = S_OUT;
          end else begin
            scan_idx_nxt = scan_idx_r + SLOT_IDX_W'(1);
            state_nxt    = S_SCAN_RD;
          end
        end else begin
          state_nxt = S_SCAN_MIN;
        end
      end
      S_SCAN_MIN: begin
        if (!cmp_le) begin
          least_nxt = slot_data;
        end
        if (scan_last) begin
          due_nxt   = (!cmp_le) ? slot_data : least_r;
          state_nxt = S_OUT;
        end else begin
          scan_idx_nxt = scan_idx_r + SLOT_IDX_W'(1);
          state_nxt    = S_SCAN_RD;
        end
      end
      S_OUT: begin
        out_nxt.status        = status_r;
        out_nxt.slot_time     = get_time_r;
        out_nxt.slot_armed    = get_armed_r;
        out_nxt.current_time  = tick_r;
        out_nxt.next_due_time = due_r;
        out_nxt.tick_event    = flag_r;
        out_nxt.fired_mask    = 16'(fired_r);
        out_nxt.armed_mask    = 16'(armed_r);
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd0;
      due_r       <= TIME_ALL_ONES;
      armed_r     <= '0;
      fired_r     <= '0;
      valid_r     <= '0;
      flag_r      <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      due_r       <= due_nxt;
      armed_r     <= armed_nxt;
      fired_r     <= fired_nxt;
      valid_r     <= valid_nxt;
      flag_r      <= flag_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r      <= item_nxt;
    least_r     <= least_nxt;
    status_r    <= status_nxt;
    get_time_r  <= get_time_nxt;
    get_armed_r <= get_armed_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_item.alarm_time;
    end
    if (mem_re) begin
      rd_data_r  <= mem[mem_addr];
      rd_valid_r <= valid_r[mem_addr];
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `MSAS_ASSERT(a_out_when_idle, !out_valid || !busy, "result beat while sequencer busy")
  `MSAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
  `MSAS_ASSERT(a_done_strobe,
               !($fell(busy) && $past(rst_n)) || out_valid,
               "work ended without a result beat")
  `MSAS_ASSERT(a_bad_slot_clean,
               !(out_valid && out_item.status) ||
               (out_item.slot_time == 32'd0 && !out_item.slot_armed),
               "failed request returned slot data")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the multi-slot alarm scheduler
// Directed commands, then random traffic under three sender idle profiles.
// Every result beat is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import msas_pkg::*;

  // Opcodes outside the defined set; the block must treat them as no-ops.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  always #10 clk = ~clk;

  multi_slot_alarm_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Model state of the scheduler.
  logic [31:0] ticks_now;
  logic [31:0] due_time;
  logic [15:0] armed_now;
  logic [15:0] fired_now;
  logic        tick_seen;
  logic [31:0] alarm_at [SLOT_COUNT];

  out_item_t expected_snapshots[$];
  out_item_t want_snap;
  int        fail_count = 0;
  int        sender_idle_pct;
  int        idle_cycles = 0;

  task automatic reset_schedule();
    ticks_now = '0;
    due_time  = TIME_ALL_ONES;
    armed_now = '0;
    fired_now = '0;
    tick_seen = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++) alarm_at[s] = '0;
  endtask

  // Applies one command to the model and returns the state snapshot it yields.
  function automatic out_item_t step_schedule(in_item_t cmd);
    out_item_t   snap;
    logic [31:0] least;
    logic        hit;
    snap = '0;
    snap.status = STATUS_OK;
    hit = cmd.slot_index < SLOT_COUNT;
    case (cmd.opcode)
      OP_TICK: begin
        ticks_now = ticks_now + 32'd1;
        if (due_time <= ticks_now) tick_seen = 1'b1;
      end
      OP_SET: begin
        if (!hit) begin
          snap.status = STATUS_BAD_SLOT;
        end else begin
          alarm_at[cmd.slot_index] = cmd.alarm_time;
          armed_now[cmd.slot_index] = cmd.enable;
          // The due time drops even when the slot is being disarmed.
          if (cmd.alarm_time < due_time) due_time = cmd.alarm_time;
        end
      end
      OP_GET: begin
        if (!hit) begin
          snap.status = STATUS_BAD_SLOT;
        end else begin
          snap.slot_time  = alarm_at[cmd.slot_index];
          snap.slot_armed = armed_now[cmd.slot_index];
        end
      end
      OP_SCAN: begin
        if (armed_now != '0) begin
          least = TIME_ALL_ONES;
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (armed_now[s]) begin
              if (alarm_at[s] <= ticks_now) begin
                armed_now[s] = 1'b0;
                fired_now[s] = 1'b1;
              end else if (alarm_at[s] < least) begin
                least = alarm_at[s];
              end
            end
          end
          due_time = least;
        end
      end
      OP_CLR_TICK:  tick_seen = 1'b0;
      OP_CLR_FIRED: fired_now = '0;
      default: ;
    endcase
    snap.current_time  = ticks_now;
    snap.next_due_time = due_time;
    snap.tick_event    = tick_seen;
    snap.fired_mask    = fired_now;
    snap.armed_mask    = armed_now;
    return snap;
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] op, logic [3:0] idx,
                                        logic [31:0] when, logic en);
    in_item_t c;
    c.opcode     = op;
    c.slot_index = idx;
    c.alarm_time = when;
    c.enable     = en;
    return c;
  endfunction

  // Idles for a random number of cycles, then holds start until the beat is taken.
  task automatic send_command(in_item_t cmd);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    expected_snapshots.push_back(step_schedule(cmd));
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_snapshots.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_item);
        fail_count++;
      end else begin
        want_snap = expected_snapshots.pop_front();
        compare_field("status", 32'(want_snap.status), 32'(out_item.status));
        compare_field("slot_time", want_snap.slot_time, out_item.slot_time);
        compare_field("slot_armed", 32'(want_snap.slot_armed), 32'(out_item.slot_armed));
        compare_field("current_time", want_snap.current_time, out_item.current_time);
        compare_field("next_due_time", want_snap.next_due_time, out_item.next_due_time);
        compare_field("tick_event", 32'(want_snap.tick_event), 32'(out_item.tick_event));
        compare_field("fired_mask", 32'(want_snap.fired_mask), 32'(out_item.fired_mask));
        compare_field("armed_mask", 32'(want_snap.armed_mask), 32'(out_item.armed_mask));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_view();
    send_command(make_cmd(OP_GET, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_GET, 4'(SLOT_COUNT - 1), 32'h0, 1'b0));
  endtask

  task automatic test_bad_slot();
    send_command(make_cmd(OP_SET, 4'(SLOT_COUNT), 32'h1234_5678, 1'b1));
    send_command(make_cmd(OP_GET, 4'd15, 32'h0, 1'b0));
  endtask

  task automatic test_set_get_extremes();
    send_command(make_cmd(OP_SET, 4'd0, TIME_ALL_ONES, 1'b1));
    send_command(make_cmd(OP_GET, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_SET, 4'(SLOT_COUNT - 1), 32'h0, 1'b0));
    send_command(make_cmd(OP_GET, 4'(SLOT_COUNT - 1), 32'h0, 1'b0));
  endtask

  task automatic test_tick_event();
    send_command(make_cmd(OP_TICK, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_CLR_TICK, 4'd0, 32'h0, 1'b0));
  endtask

  task automatic test_scan();
    send_command(make_cmd(OP_SCAN, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_SET, 4'd3, 32'd3, 1'b1));
    send_command(make_cmd(OP_TICK, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_TICK, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_SCAN, 4'd0, 32'h0, 1'b0));
  endtask

  // A scan with nothing armed must leave the due time alone.
  task automatic test_scan_nothing_armed();
    send_command(make_cmd(OP_SET, 4'd0, 32'd5, 1'b0));
    send_command(make_cmd(OP_SCAN, 4'd0, 32'h0, 1'b0));
  endtask

  task automatic test_clear_ops();
    send_command(make_cmd(OP_CLR_TICK, 4'd0, 32'h0, 1'b0));
    send_command(make_cmd(OP_CLR_FIRED, 4'd0, 32'h0, 1'b0));
  endtask

  task automatic test_spare_opcodes();
    send_command(make_cmd(OP_SPARE_A, 4'd2, 32'hDEAD_BEEF, 1'b1));
    send_command(make_cmd(OP_SPARE_B, 4'd9, 32'h0F0F_0F0F, 1'b0));
  endtask

  // Alarm times mostly land a few ticks around the current time so that
  // ticks and scans actually reach them.
  function automatic in_item_t random_command();
    in_item_t c;
    int       pick;
    c.slot_index = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(SLOT_COUNT - 1));
    c.enable = ($urandom_range(3) != 0);
    case ($urandom_range(7))
      0:       c.alarm_time = $urandom();
      1:       c.alarm_time = 32'h0;
      2:       c.alarm_time = TIME_ALL_ONES;
      default: c.alarm_time = ticks_now + 32'($urandom_range(28)) - 32'd4;
    endcase
    pick = $urandom_range(99);
    if (pick < 36)      c.opcode = OP_TICK;
    else if (pick < 60) c.opcode = OP_SET;
    else if (pick < 72) c.opcode = OP_GET;
    else if (pick < 86) c.opcode = OP_SCAN;
    else if (pick < 92) c.opcode = OP_CLR_TICK;
    else if (pick < 97) c.opcode = OP_CLR_FIRED;
    else                c.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    return c;
  endfunction

  task automatic test_random(int count);
    repeat (count) send_command(random_command());
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    sender_idle_pct = 26;
    reset_schedule();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_view();
    test_bad_slot();
    test_set_get_extremes();
    test_tick_event();
    test_scan();
    test_scan_nothing_armed();
    test_clear_ops();
    test_spare_opcodes();

    test_random(450);
    sender_idle_pct = 59;
    test_random(450);
    sender_idle_pct = 0;
    test_random(450);

    start <= 1'b0;
    while (expected_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
